@@ src/rld_pkg.sv @@
package rld_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 7;
   localparam int DATA_W  = 64;
   localparam int LANE_W  = 4;
   localparam int SKIP_W  = 18;

   localparam logic [BYTE_W-1:0] HDR_END     = 8'hFF;
   localparam logic [BYTE_W-1:0] HDR_LITERAL = 8'h80;
   localparam logic [BYTE_W-1:0] HDR_MASK    = 8'h7F;

   // One decoded command: a byte repeated len times, len zero for an end-only result.
   typedef struct packed {
      logic [BYTE_W-1:0]  value;
      logic [COUNT_W-1:0] len;
      logic               stream_end;
   } rld_cmd_type;

   typedef enum logic [4:0] {
      PH_SKIP   = 5'b00001,
      PH_HEAD   = 5'b00010,
      PH_RUNVAL = 5'b00100,
      PH_LIT    = 5'b01000,
      PH_DONE   = 5'b10000
   } rld_phase_type;

endpackage

@@ src/rld_front.sv @@
module rld_front #(
   parameter int MAX_COUNT = 127
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,
   input  logic                        req_tlast,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rld_pkg::SKIP_W-1:0]  csr_data,
   output logic                        cmd_valid,
   input  logic                        cmd_ready,
   output rld_pkg::rld_cmd_type        cmd
);
   import rld_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_W = COUNT_W'(MAX_COUNT);

   rld_phase_type      phase_ff, phase_in, eff_phase;
   logic [SKIP_W-1:0]  skip_left_ff, skip_left_in;
   logic [SKIP_W-1:0]  start_offset_ff, start_offset_in;
   logic [COUNT_W-1:0] literal_left_ff, literal_left_in;
   logic [COUNT_W-1:0] run_length_ff, run_length_in;
   logic [COUNT_W-1:0] low_count, header_count, lit_count;
   logic               accept;

   assign req_tready = cmd_ready;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   assign low_count    = req_tdata[COUNT_W-1:0];
   assign header_count = (low_count > MAX_W) ? MAX_W : low_count;
   assign lit_count    = literal_left_ff - COUNT_W'(1);
   assign eff_phase    = (phase_ff == PH_SKIP && skip_left_ff == '0) ? PH_HEAD : phase_ff;

   always_comb begin
      phase_in        = phase_ff;
      skip_left_in    = skip_left_ff;
      start_offset_in = start_offset_ff;
      literal_left_in = literal_left_ff;
      run_length_in   = run_length_ff;
      cmd_valid       = 1'b0;
      cmd.value       = req_tdata;
      cmd.len         = COUNT_W'(1);
      cmd.stream_end  = req_tlast;
      if (accept) begin
         if (phase_ff == PH_SKIP && skip_left_ff != '0) begin
            skip_left_in = skip_left_ff - SKIP_W'(1);
         end else begin
            phase_in = eff_phase;
            unique case (eff_phase)
               PH_HEAD: begin
                  if (req_tdata == HDR_END) begin
                     cmd_valid      = 1'b1;
                     cmd.value      = '0;
                     cmd.len        = '0;
                     cmd.stream_end = 1'b1;
                     phase_in       = PH_DONE;
                  end else if (req_tdata < HDR_LITERAL) begin
                     run_length_in = header_count;
                     phase_in      = PH_RUNVAL;
                  end else begin
                     literal_left_in = header_count;
                     phase_in        = (header_count != '0) ? PH_LIT : PH_HEAD;
                  end
               end
               PH_RUNVAL: begin
                  cmd_valid     = (run_length_ff != '0);
                  cmd.len       = run_length_ff;
                  run_length_in = '0;
                  phase_in      = PH_HEAD;
               end
               PH_LIT: begin
                  cmd_valid = 1'b1;
                  if (literal_left_ff != '0) begin
                     literal_left_in = lit_count;
                  end
                  if (literal_left_ff == '0 || lit_count == '0) begin
                     phase_in = PH_HEAD;
                  end
               end
               PH_SKIP, PH_DONE: begin
               end
               default: begin
               end
            endcase
         end
         if (req_tlast) begin
            // The source ended: close the stream unless a terminator already did.
            if (!cmd_valid && phase_ff != PH_DONE) begin
               cmd_valid      = 1'b1;
               cmd.value      = '0;
               cmd.len        = '0;
               cmd.stream_end = 1'b1;
            end
            phase_in        = PH_SKIP;
            skip_left_in    = start_offset_ff;
            literal_left_in = '0;
            run_length_in   = '0;
         end
      end
      if (csr_valid && csr_ready) begin
         start_offset_in = csr_data;
         if (phase_in == PH_SKIP) begin
            skip_left_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SKIP;
         skip_left_ff    <= '0;
         start_offset_ff <= '0;
         literal_left_ff <= '0;
         run_length_ff   <= '0;
      end else begin
         phase_ff        <= phase_in;
         skip_left_ff    <= skip_left_in;
         start_offset_ff <= start_offset_in;
         literal_left_ff <= literal_left_in;
         run_length_ff   <= run_length_in;
      end
   end

endmodule

@@ src/rld_queue.sv @@
module rld_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  rld_pkg::rld_cmd_type push_cmd,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output rld_pkg::rld_cmd_type pop_cmd
);
   import rld_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   rld_cmd_type      entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != (PTR_W+1)'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

@@ src/rld_back.sv @@
module rld_back #(
   parameter int OUT_LANES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  rld_pkg::rld_cmd_type cmd,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);
   import rld_pkg::*;

   localparam int MAX_LANES = DATA_W / BYTE_W;
   localparam logic [COUNT_W-1:0] LANES_W = COUNT_W'(OUT_LANES);

   logic [COUNT_W-1:0] sent_ff, sent_in, remain, chunk;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic [LANE_W-1:0]  count_ff;
   logic               end_ff, last_ff, valid_ff, valid_in;
   logic               load, final_chunk;

   assign remain      = cmd.len - sent_ff;
   assign final_chunk = (remain <= LANES_W);
   assign chunk       = final_chunk ? remain : LANES_W;
   assign load        = cmd_valid && (!valid_ff || rsp_tready);
   assign cmd_ready   = load && final_chunk;

   always_comb begin
      for (int j = 0; j < MAX_LANES; j++) begin
         data_in[j*BYTE_W +: BYTE_W] = (COUNT_W'(j) < chunk) ? cmd.value : '0;
      end
      sent_in  = sent_ff;
      valid_in = valid_ff;
      if (load) begin
         sent_in  = final_chunk ? '0 : sent_ff + LANES_W;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff  <= data_in;
         count_ff <= chunk[LANE_W-1:0];
         end_ff   <= final_chunk && cmd.stream_end;
         last_ff  <= final_chunk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, count_ff, data_ff};
   assign rsp_tuser  = end_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ src/rle_literal_run_decoder.sv @@
// Run/literal byte stream decoder.
// The req channel takes one compressed source byte per item, tlast marking
// the final byte of the source. After start_offset leading bytes are skipped,
// header bytes select a run (the next byte repeated), a literal block (bytes
// passed through one per result) or the terminator 0xFF. The rsp channel
// gives results of up to OUT_LANES bytes with a byte count; tuser flags the
// result that ends the stream and tlast the last result caused by an item.
// The csr channel writes start_offset and is always ready; it is meant to be
// written while the decoder is idle.
// A result is registered first in the command queue, then in the output register.
// Throughput: one item per cycle while each item yields at most one result
// and rsp_tready stays high. A run byte of length L is split into
// ceil(L / OUT_LANES) results by the single output register; the two-entry
// command queue then fills and req stalls until the expansion drains.
// Reset clears the decoder state, the queue and the output valid flag, and
// start_offset returns to zero. When the receiver stalls, the output holds,
// the queue fills and req_tready drops.
module rle_literal_run_decoder #(
   parameter int OUT_LANES = 8,
   parameter int MAX_COUNT = 127
) (
   input  logic                        clock,
   input  logic                        reset,
   // Source bytes.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // in_byte [7:0]
   input  logic                        req_tlast,   // in_last
   // Decoded results.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [71:0]                 rsp_tdata,   // out_data [63:0], out_count [67:64]
   output logic                        rsp_tuser,   // stream_end
   output logic                        rsp_tlast,   // last
   // Start offset register.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rld_pkg::SKIP_W-1:0]  csr_data
);
   import rld_pkg::*;

   // Commands from the parser to the expander.
   rld_cmd_type front_cmd, back_cmd;
   logic        front_valid, front_ready, back_valid, back_ready;

   // The front parses headers and tracks the skip, run and literal counters.
   rld_front #(
      .MAX_COUNT (MAX_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   // A short queue lets the parser keep going while a run is expanded.
   rld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (back_cmd)
   );

   // The back splits each command into packed output words.
   rld_back #(
      .OUT_LANES (OUT_LANES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
